// File: rtl/triangle_plane_clip_defines.svh
// Assertion macros used by the back end of the triangle clipper.
`ifndef TRIANGLE_PLANE_CLIP_DEFINES_SVH
`define TRIANGLE_PLANE_CLIP_DEFINES_SVH
`ifndef SYNTHESIS
// Checks an expression at every rising clock edge outside reset.
`define TPC_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
// Checks that a condition implies a consequence in the same cycle.
`define TPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define TPC_ASSERT(lbl, expr, msg)
`define TPC_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/tpc_pkg.sv
// Shared types, constants and case tables of the triangle clipper.
package tpc_pkg;

    localparam int CoordBits  = 32;
    localparam int QueueDepth = 2;

    // Mask of clipped vertices, bit i set when distance i is negative.
    localparam logic [2:0] MASK_NONE = 3'd0;
    localparam logic [2:0] MASK_V0   = 3'd1;
    localparam logic [2:0] MASK_V1   = 3'd2;
    localparam logic [2:0] MASK_V01  = 3'd3;
    localparam logic [2:0] MASK_V2   = 3'd4;
    localparam logic [2:0] MASK_V02  = 3'd5;
    localparam logic [2:0] MASK_V12  = 3'd6;
    localparam logic [2:0] MASK_ALL  = 3'd7;

    typedef struct packed {
        logic [1:0] a_i;
        logic [1:0] a_j;
        logic [1:0] b_i;
        logic [1:0] b_j;
    } t_edges;

    localparam int EdgesBits = $bits(t_edges);

    typedef enum logic [2:0] {
        C_V0, C_V1, C_V2, C_A, C_B
    } t_corner;

    typedef struct packed {
        t_corner c0;
        t_corner c1;
        t_corner c2;
    } t_tri_sel;

    typedef enum logic [1:0] {
        LN_IDLE, LN_MUL, LN_DIV, LN_FIN
    } t_lane_st;

    typedef enum logic [1:0] {
        BK_IDLE, BK_CALC, BK_OUT0, BK_OUT1
    } t_back_st;

    // Endpoints of the two new edge points for each clip case.
    function automatic t_edges tpc_edges(input logic [2:0] mask);
        t_edges e;
        unique case (mask)
            MASK_V0, MASK_V12: e = '{a_i: 2'd0, a_j: 2'd1, b_i: 2'd0, b_j: 2'd2};
            MASK_V1, MASK_V02: e = '{a_i: 2'd0, a_j: 2'd1, b_i: 2'd1, b_j: 2'd2};
            MASK_V2:           e = '{a_i: 2'd1, a_j: 2'd2, b_i: 2'd0, b_j: 2'd2};
            MASK_V01:          e = '{a_i: 2'd0, a_j: 2'd2, b_i: 2'd1, b_j: 2'd2};
            default:           e = '{a_i: 2'd0, a_j: 2'd1, b_i: 2'd0, b_j: 2'd2};
        endcase
        return e;
    endfunction

    // Number of triangles that a clip case produces.
    function automatic logic [1:0] tpc_tri_count(input logic [2:0] mask);
        logic [1:0] n;
        unique case (mask)
            MASK_V0, MASK_V1, MASK_V2: n = 2'd2;
            MASK_ALL:                  n = 2'd0;
            default:                   n = 2'd1;
        endcase
        return n;
    endfunction

    // Corners of the first or second output triangle, winding preserved.
    function automatic t_tri_sel tpc_corners(input logic [2:0] mask, input logic second);
        t_tri_sel s;
        unique case (mask)
            MASK_V0:  s = second ? '{C_A, C_V2, C_B}  : '{C_A, C_V1, C_V2};
            MASK_V1:  s = second ? '{C_V2, C_A, C_B}  : '{C_V0, C_A, C_V2};
            MASK_V2:  s = second ? '{C_B, C_V1, C_A}  : '{C_V0, C_V1, C_B};
            MASK_V01: s = '{C_A, C_B, C_V2};
            MASK_V02: s = '{C_A, C_V1, C_B};
            MASK_V12: s = '{C_V0, C_A, C_B};
            default:  s = '{C_V0, C_V1, C_V2};
        endcase
        return s;
    endfunction

endpackage

// File: rtl/tpc_front.sv
// Front end: classifies an incoming triangle and packs it into a queue entry.
module tpc_front #(
    parameter int W       = tpc_pkg::CoordBits,
    parameter int ENTRY_W = 12 * W + 3 + tpc_pkg::EdgesBits
) (
    input  logic [W-1:0]       i_v [3][3],
    input  logic [W-1:0]       i_d [3],
    output logic [ENTRY_W-1:0] o_entry
);

    logic [2:0]     mask;
    tpc_pkg::t_edges edges;

    // A vertex is clipped when its distance is negative; zero is kept.
    assign mask  = {i_d[2][W-1], i_d[1][W-1], i_d[0][W-1]};
    assign edges = tpc_pkg::tpc_edges(mask);

    // Pack vertices, distances, mask and edge endpoints.
    always_comb begin
        o_entry = '0;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                o_entry[(i*3+k)*W +: W] = i_v[i][k];
            end
            o_entry[(9+i)*W +: W] = i_d[i];
        end
        o_entry[12*W +: 3]                  = mask;
        o_entry[12*W+3 +: tpc_pkg::EdgesBits] = edges;
    end

endmodule

// File: rtl/tpc_queue.sv
// Short first-in first-out queue between the front and back ends.
module tpc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tpc_pkg::QueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// File: rtl/tpc_lerp.sv
// One interpolation lane: a + (b - a) * |da| / |da - db|, truncated toward a.
module tpc_lerp #(
    parameter int W = tpc_pkg::CoordBits
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_da,
    input  logic [W-1:0] i_db,
    output logic         o_done,
    output logic [W-1:0] o_res
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    tpc_pkg::t_lane_st r_st, n_st;
    logic          r_done, n_done;
    logic [W-1:0]  r_a, r_span, r_num, r_den, r_rem, r_lo, r_res;
    logic          r_up;
    logic [CW-1:0] r_cnt;

    logic         up;
    logic [W:0]   diff, ndiff, dd, ndd;
    logic [W-1:0] span, num, den;
    logic [2*W-1:0] prod;
    logic [W:0]   trial, tsub;
    logic         ge;
    logic [W-1:0] off;

    // Operand preparation: magnitude of span, of the numerator and of the divisor.
    always_comb begin
        up    = ($signed(i_b) >= $signed(i_a));
        diff  = {i_b[W-1], i_b} - {i_a[W-1], i_a};
        ndiff = '0 - diff;
        span  = up ? diff[W-1:0] : ndiff[W-1:0];
        num   = i_da[W-1] ? ('0 - i_da) : i_da;
        dd    = {i_da[W-1], i_da} - {i_db[W-1], i_db};
        ndd   = '0 - dd;
        den   = dd[W] ? ndd[W-1:0] : dd[W-1:0];
    end

    // Product and one restoring division step.
    assign prod  = r_span * r_num;
    assign trial = {r_rem, r_lo[W-1]};
    assign tsub  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});
    assign off   = (r_den == '0) ? '0 : r_lo;

    // Sequencer of the lane.
    always_comb begin
        n_st   = r_st;
        n_done = 1'b0;
        unique case (r_st)
            tpc_pkg::LN_IDLE: if (i_start) n_st = tpc_pkg::LN_MUL;
            tpc_pkg::LN_MUL:  n_st = tpc_pkg::LN_DIV;
            tpc_pkg::LN_DIV:  if (r_cnt == CW'(W - 1)) n_st = tpc_pkg::LN_FIN;
            tpc_pkg::LN_FIN: begin
                n_st   = tpc_pkg::LN_IDLE;
                n_done = 1'b1;
            end
            default:          n_st = tpc_pkg::LN_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= tpc_pkg::LN_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_st == tpc_pkg::LN_IDLE && i_start) begin
            r_a    <= i_a;
            r_up   <= up;
            r_span <= span;
            r_num  <= num;
            r_den  <= den;
        end
        if (r_st == tpc_pkg::LN_MUL) begin
            r_rem <= prod[2*W-1:W];
            r_lo  <= prod[W-1:0];
            r_cnt <= '0;
        end
        if (r_st == tpc_pkg::LN_DIV) begin
            r_rem <= ge ? tsub[W-1:0] : trial[W-1:0];
            r_lo  <= {r_lo[W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_st == tpc_pkg::LN_FIN) begin
            r_res <= r_up ? (r_a + off) : (r_a - off);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: rtl/tpc_back.sv
// Back end: computes the edge points and emits the clipped triangles.
`include "triangle_plane_clip_defines.svh"
module tpc_back #(
    parameter int W       = tpc_pkg::CoordBits,
    parameter int ENTRY_W = 12 * W + 3 + tpc_pkg::EdgesBits
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  logic [ENTRY_W-1:0] i_q_data,
    output logic               o_q_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [W-1:0]       o_tri [3][3],
    output logic               o_last
);

    tpc_pkg::t_back_st r_st, n_st;
    logic [W-1:0]  qv [3][3];
    logic [W-1:0]  qd [3];
    logic [2:0]    qmask;
    tpc_pkg::t_edges qedges;
    logic [W-1:0]  r_v [3][3];
    logic [2:0]    r_mask;
    logic [W-1:0]  lane_a [6], lane_b [6], lane_da [6], lane_db [6], lane_res [6];
    logic [5:0]    lane_done;
    logic          lane_start;
    logic          r_ov, n_ov;
    logic [W-1:0]  r_out [3][3];
    logic          r_last;
    logic          out_free, emit, emit_second, is_pass;
    tpc_pkg::t_tri_sel sel;
    tpc_pkg::t_corner  csel [3];

    // Unpack the queue head.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                qv[i][k] = i_q_data[(i*3+k)*W +: W];
            end
            qd[i] = i_q_data[(9+i)*W +: W];
        end
        qmask  = i_q_data[12*W +: 3];
        qedges = i_q_data[12*W+3 +: tpc_pkg::EdgesBits];
    end

    // Lanes 0..2 give point A, lanes 3..5 point B, one per coordinate.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lane_a[k]    = qv[qedges.a_i][k];
            lane_b[k]    = qv[qedges.a_j][k];
            lane_da[k]   = qd[qedges.a_i];
            lane_db[k]   = qd[qedges.a_j];
            lane_a[3+k]  = qv[qedges.b_i][k];
            lane_b[3+k]  = qv[qedges.b_j][k];
            lane_da[3+k] = qd[qedges.b_i];
            lane_db[3+k] = qd[qedges.b_j];
        end
    end

    for (genvar g = 0; g < 6; g++) begin : g_lane
        tpc_lerp #(.W(W)) u_lerp (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (lane_start),
            .i_a     (lane_a[g]),
            .i_b     (lane_b[g]),
            .i_da    (lane_da[g]),
            .i_db    (lane_db[g]),
            .o_done  (lane_done[g]),
            .o_res   (lane_res[g])
        );
    end

    assign out_free    = !r_ov || i_pop;
    assign is_pass     = (qmask == tpc_pkg::MASK_NONE);
    assign emit_second = (r_st == tpc_pkg::BK_OUT1);
    assign sel         = tpc_pkg::tpc_corners(r_mask, emit_second);
    assign csel[0]     = sel.c0;
    assign csel[1]     = sel.c1;
    assign csel[2]     = sel.c2;

    // Sequencer: take an entry, wait for the lanes if it is clipped, emit none, one or two triangles.
    always_comb begin
        n_st       = r_st;
        o_q_pop    = 1'b0;
        lane_start = 1'b0;
        emit       = 1'b0;
        unique case (r_st)
            tpc_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (is_pass) begin
                        n_st = tpc_pkg::BK_OUT0;
                    end else if (qmask != tpc_pkg::MASK_ALL) begin
                        lane_start = 1'b1;
                        n_st       = tpc_pkg::BK_CALC;
                    end
                end
            end
            tpc_pkg::BK_CALC: begin
                if (lane_done[0]) n_st = tpc_pkg::BK_OUT0;
            end
            tpc_pkg::BK_OUT0: begin
                if (out_free) begin
                    emit = 1'b1;
                    n_st = (tpc_pkg::tpc_tri_count(r_mask) == 2'd2) ? tpc_pkg::BK_OUT1
                                                                     : tpc_pkg::BK_IDLE;
                end
            end
            tpc_pkg::BK_OUT1: begin
                if (out_free) begin
                    emit = 1'b1;
                    n_st = tpc_pkg::BK_IDLE;
                end
            end
            default: n_st = tpc_pkg::BK_IDLE;
        endcase
    end

    // The output register holds one triangle until it is taken.
    always_comb begin
        n_ov = r_ov;
        if (i_pop) n_ov = 1'b0;
        if (emit)  n_ov = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tpc_pkg::BK_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
        end
    end

    // Corner selection into the output register.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_v    <= qv;
            r_mask <= qmask;
        end
        if (emit) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    unique case (csel[c])
                        tpc_pkg::C_V0: r_out[c][k] <= r_v[0][k];
                        tpc_pkg::C_V1: r_out[c][k] <= r_v[1][k];
                        tpc_pkg::C_V2: r_out[c][k] <= r_v[2][k];
                        tpc_pkg::C_A:  r_out[c][k] <= lane_res[k];
                        tpc_pkg::C_B:  r_out[c][k] <= lane_res[3+k];
                        default:       r_out[c][k] <= r_v[0][k];
                    endcase
                end
            end
            r_last <= emit_second || (tpc_pkg::tpc_tri_count(r_mask) != 2'd2);
        end
    end

    assign o_empty = !r_ov;
    assign o_tri   = r_out;
    assign o_last  = r_last;

    // All lanes start together and must finish together.
    `TPC_ASSERT(a_lanes_in_step, (lane_done == '0) || (lane_done == '1), "lanes out of step")
    // Lane results arrive only while the sequencer waits for them.
    `TPC_ASSERT_IMP(a_done_in_calc, |lane_done, r_st == tpc_pkg::BK_CALC, "stray lane result")
    // The queue is never read while it is empty.
    `TPC_ASSERT_IMP(a_pop_nonempty, o_q_pop, !i_q_empty, "pop from empty queue")
    // A second triangle always follows a first one.
    `TPC_ASSERT_IMP(a_second_after_first, r_st == tpc_pkg::BK_OUT1,
                    $past(r_st) == tpc_pkg::BK_OUT0 || $past(r_st) == tpc_pkg::BK_OUT1,
                    "second triangle without first")

endmodule

// File: rtl/triangle_plane_clip.sv
// Top level of the triangle clipper against a single plane.
//
// Input channel: a triangle (three vertices of x, y, z and a clip distance
// per vertex) is written with push while full is low. Result channel: each
// output triangle with its last_tri flag stands on the result ports while
// empty is low, and pop takes it.
// A front end classifies the request by the signs of the distances and puts
// it in a short queue; the back end reads the queue and runs six
// interpolation lanes, one per coordinate of the two new edge points.
// A request that needs no clipping passes from the queue through the back
// end to the output register without the lanes; the back end takes a new
// entry only once it is done with the current one. A clipped request
// also waits for the bit-serial divider in each lane; a fully clipped one
// is dropped with no output triangle.
// The front keeps accepting requests until the queue is full.
// When the receiver stalls the pending triangle holds in the output
// register and the back end waits behind it.
// Reset empties the queue and output register and idles the sequencers.
module triangle_plane_clip #(
    parameter int COORD_BITS  = tpc_pkg::CoordBits,
    parameter int QUEUE_DEPTH = tpc_pkg::QueueDepth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [COORD_BITS-1:0] i_v0_x,
    input  logic [COORD_BITS-1:0] i_v0_y,
    input  logic [COORD_BITS-1:0] i_v0_z,
    input  logic [COORD_BITS-1:0] i_v1_x,
    input  logic [COORD_BITS-1:0] i_v1_y,
    input  logic [COORD_BITS-1:0] i_v1_z,
    input  logic [COORD_BITS-1:0] i_v2_x,
    input  logic [COORD_BITS-1:0] i_v2_y,
    input  logic [COORD_BITS-1:0] i_v2_z,
    input  logic [COORD_BITS-1:0] i_dist0,
    input  logic [COORD_BITS-1:0] i_dist1,
    input  logic [COORD_BITS-1:0] i_dist2,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_BITS-1:0] o_out0_x,
    output logic [COORD_BITS-1:0] o_out0_y,
    output logic [COORD_BITS-1:0] o_out0_z,
    output logic [COORD_BITS-1:0] o_out1_x,
    output logic [COORD_BITS-1:0] o_out1_y,
    output logic [COORD_BITS-1:0] o_out1_z,
    output logic [COORD_BITS-1:0] o_out2_x,
    output logic [COORD_BITS-1:0] o_out2_y,
    output logic [COORD_BITS-1:0] o_out2_z,
    output logic                  o_last_tri
);

    localparam int EntryW = 12 * COORD_BITS + 3 + tpc_pkg::EdgesBits;

    logic [COORD_BITS-1:0] in_v [3][3];
    logic [COORD_BITS-1:0] in_d [3];
    logic [COORD_BITS-1:0] tri_c [3][3];
    logic [EntryW-1:0]     wr_entry, rd_entry;
    logic                  q_empty, q_pop;

    // Gather the input fields.
    assign in_v[0] = '{i_v0_x, i_v0_y, i_v0_z};
    assign in_v[1] = '{i_v1_x, i_v1_y, i_v1_z};
    assign in_v[2] = '{i_v2_x, i_v2_y, i_v2_z};
    assign in_d    = '{i_dist0, i_dist1, i_dist2};

    tpc_front #(.W(COORD_BITS), .ENTRY_W(EntryW)) u_front (
        .i_v     (in_v),
        .i_d     (in_d),
        .o_entry (wr_entry)
    );

    tpc_queue #(.WIDTH(EntryW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (wr_entry),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (rd_entry)
    );

    tpc_back #(.W(COORD_BITS), .ENTRY_W(EntryW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (rd_entry),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_tri     (tri_c),
        .o_last    (o_last_tri)
    );

    // Spread the output triangle onto its ports.
    assign o_out0_x = tri_c[0][0];
    assign o_out0_y = tri_c[0][1];
    assign o_out0_z = tri_c[0][2];
    assign o_out1_x = tri_c[1][0];
    assign o_out1_y = tri_c[1][1];
    assign o_out1_z = tri_c[1][2];
    assign o_out2_x = tri_c[2][0];
    assign o_out2_y = tri_c[2][1];
    assign o_out2_z = tri_c[2][2];

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench of the triangle clipper: predicts output triangles and checks them in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef logic [W-1:0] t_word;

    // One input request: nine coordinates and three distances.
    typedef struct {
        t_word c[9];
        t_word d[3];
    } t_tri_in;

    // One output triangle.
    typedef struct {
        t_word c[9];
        logic  last;
    } t_tri_out;

    int fail_count = 0;

    // Prints one mismatch line and counts it.
    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Scoreboard: predicts the clipped triangles and compares them in order.
    class clip_scoreboard;
        t_tri_out pending[$];

        // Exact point on edge a-b where the distance crosses zero, truncated toward a.
        static function t_word edge_coord(t_word a, t_word b, t_word da, t_word db);
            logic signed [W:0] sa, sb, sda, sdb;
            logic [W:0] span, num, den;
            logic [2*W+1:0] prod, off;
            sa = $signed(a); sb = $signed(b);
            sda = $signed(da); sdb = $signed(db);
            span = (sb >= sa) ? sb - sa : sa - sb;
            num = (sda < 0) ? -sda : sda;
            den = (sda >= sdb) ? sda - sdb : sdb - sda;
            prod = span * num;
            off = (den == 0) ? '0 : prod / den;
            return (sb >= sa) ? a + off[W-1:0] : a - off[W-1:0];
        endfunction

        function void add_tri(t_word p[3][3], int i0, int i1, int i2, logic last);
            t_tri_out t;
            for (int k = 0; k < 3; k++) begin
                t.c[k] = p[i0][k];
                t.c[3+k] = p[i1][k];
                t.c[6+k] = p[i2][k];
            end
            t.last = last;
            pending.push_back(t);
        endfunction

        // Notes an accepted request and queues its expected triangles.
        function void note_request(t_tri_in r);
            logic [2:0] mask;
            int ai, aj, bi, bj;
            // Points 0..2 are the vertices, 3 is A and 4 is B.
            t_word p[5][3];
            t_word q[3][3];
            for (int i = 0; i < 3; i++) begin
                mask[i] = r.d[i][W-1];
                for (int k = 0; k < 3; k++) p[i][k] = r.c[i*3+k];
            end
            ai = 0; aj = 1; bi = 0; bj = 2;
            case (mask)
                tpc_pkg::MASK_V1, tpc_pkg::MASK_V02: begin bi = 1; end
                tpc_pkg::MASK_V2: begin ai = 1; aj = 2; end
                tpc_pkg::MASK_V01: begin aj = 2; bi = 1; end
                default: ;
            endcase
            for (int k = 0; k < 3; k++) begin
                p[3][k] = edge_coord(p[ai][k], p[aj][k], r.d[ai], r.d[aj]);
                p[4][k] = edge_coord(p[bi][k], p[bj][k], r.d[bi], r.d[bj]);
            end
            case (mask)
                tpc_pkg::MASK_NONE: begin
                    q = '{p[0], p[1], p[2]}; add_tri(q, 0, 1, 2, 1);
                end
                tpc_pkg::MASK_V0: begin
                    q = '{p[3], p[1], p[2]}; add_tri(q, 0, 1, 2, 0);
                    q = '{p[3], p[2], p[4]}; add_tri(q, 0, 1, 2, 1);
                end
                tpc_pkg::MASK_V1: begin
                    q = '{p[0], p[3], p[2]}; add_tri(q, 0, 1, 2, 0);
                    q = '{p[2], p[3], p[4]}; add_tri(q, 0, 1, 2, 1);
                end
                tpc_pkg::MASK_V2: begin
                    q = '{p[0], p[1], p[4]}; add_tri(q, 0, 1, 2, 0);
                    q = '{p[4], p[1], p[3]}; add_tri(q, 0, 1, 2, 1);
                end
                tpc_pkg::MASK_V01: begin
                    q = '{p[3], p[4], p[2]}; add_tri(q, 0, 1, 2, 1);
                end
                tpc_pkg::MASK_V02: begin
                    q = '{p[3], p[1], p[4]}; add_tri(q, 0, 1, 2, 1);
                end
                tpc_pkg::MASK_V12: begin
                    q = '{p[0], p[3], p[4]}; add_tri(q, 0, 1, 2, 1);
                end
                default: ;
            endcase
        endfunction

        // Compares one accepted triangle with the oldest expectation.
        task check_result(t_tri_out got);
            t_tri_out exp_t;
            if (pending.size() == 0) begin
                report("triangle arrived with none expected");
                return;
            end
            exp_t = pending.pop_front();
            for (int i = 0; i < 9; i++)
                if (got.c[i] !== exp_t.c[i])
                    report($sformatf("corner %0d coord %0d: got %h want %h",
                        i / 3, i % 3, got.c[i], exp_t.c[i]));
            if (got.last !== exp_t.last)
                report($sformatf("last_tri: got %b want %b", got.last, exp_t.last));
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic push = 0;
    logic pop = 0;
    logic full, empty;
    t_word in_c[9];
    t_word in_d[3];
    t_word out_c[9];
    logic o_last_tri;

    clip_scoreboard sb = new();
    bit quiet = 0;
    bit stim_done = 0;
    int idle_cycles = 0;

    initial begin
        for (int i = 0; i < 9; i++) in_c[i] = '0;
        for (int i = 0; i < 3; i++) in_d[i] = '0;
    end

    triangle_plane_clip DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_v0_x(in_c[0]), .i_v0_y(in_c[1]), .i_v0_z(in_c[2]),
        .i_v1_x(in_c[3]), .i_v1_y(in_c[4]), .i_v1_z(in_c[5]),
        .i_v2_x(in_c[6]), .i_v2_y(in_c[7]), .i_v2_z(in_c[8]),
        .i_dist0(in_d[0]), .i_dist1(in_d[1]), .i_dist2(in_d[2]),
        .empty(empty), .pop(pop),
        .o_out0_x(out_c[0]), .o_out0_y(out_c[1]), .o_out0_z(out_c[2]),
        .o_out1_x(out_c[3]), .o_out1_y(out_c[4]), .o_out1_z(out_c[5]),
        .o_out2_x(out_c[6]), .o_out2_y(out_c[7]), .o_out2_z(out_c[8]),
        .o_last_tri(o_last_tri)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Random word biased towards the extremes and small values.
    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return t_word'($signed($urandom_range(0, 64)) - 32);
            4: return t_word'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
            default: return $urandom();
        endcase
    endfunction

    // Distance of chosen sign with random magnitude.
    function automatic t_word rand_dist(bit neg);
        t_word v;
        v = rand_word();
        if (neg && !v[W-1]) v = (v == 0) ? 32'hFFFF_FFFF : -v;
        if (!neg && v[W-1]) v = (v == 32'h8000_0000) ? 32'h7FFF_FFFF : -v;
        return v;
    endfunction

    // Sends one request, waiting for room in the queue; push stays high afterwards.
    task automatic send_request(t_tri_in r);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            push <= 0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        for (int i = 0; i < 9; i++) in_c[i] <= r.c[i];
        for (int i = 0; i < 3; i++) in_d[i] <= r.d[i];
        push <= 1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic send_masked(bit [2:0] m);
        t_tri_in r;
        for (int i = 0; i < 9; i++) r.c[i] = rand_word();
        for (int i = 0; i < 3; i++) r.d[i] = rand_dist(m[i]);
        send_request(r);
    endtask

    // Receiver: random stall bursts, none in the last part of the run.
    initial begin
        t_tri_out got;
        @(posedge i_rst_n);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                pop <= 0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            pop <= 1;
            @(posedge i_clk);
            if (!empty) begin
                for (int i = 0; i < 9; i++) got.c[i] = out_c[i];
                got.last = o_last_tri;
                sb.check_result(got);
            end
        end
    end

    // Watchdog on cycles with no handshake.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_tri_in r;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: every mask, extreme coordinates, zero distances.
        for (int m = 0; m < 8; m++) send_masked(m[2:0]);
        for (int i = 0; i < 9; i++) r.c[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        r.d = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_request(r);
        r.d = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
        send_request(r);
        r.d = '{32'hFFFF_FFFF, 32'd0, 32'd0};
        send_request(r);
        r.d = '{32'd0, 32'd0, 32'd0};
        send_request(r);
        r.d = '{32'd0, 32'h8000_0000, 32'd1};
        send_request(r);
        for (int i = 0; i < 9; i++) r.c[i] = '0;
        r.d = '{32'h8000_0000, 32'hFFFF_FFFF, 32'd0};
        send_request(r);
        for (int m = 0; m < 8; m++) send_masked(m[2:0]);
        push <= 0;

        // Hold off until every expected triangle has arrived.
        while (sb.pending.size() != 0) @(posedge i_clk);

        // Random part; the last stretch runs without idling.
        for (int n = 0; n < 1650; n++) begin
            if (n == 1450) quiet = 1;
            send_masked(3'($urandom_range(0, 7)));
        end
        push <= 0;
        stim_done = 1;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Guard against a silent hang after the stimulus ends.
    initial begin
        wait (stim_done);
        repeat (WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end
endmodule
